// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 block hasher: sizes, round
// constants, initial hash values, controller states and the command bundle.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int NUM_ROUNDS  = 64;
  localparam int HASH_WORDS  = 8;
  localparam int POS_W       = $clog2(BLOCK_WORDS);
  localparam int ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int IDX_W       = $clog2(HASH_WORDS);

  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(HASH_WORDS - 1);

  // Round constants
  localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining value
  localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic               load_word;   // shift a message word into the window
    logic               start;       // load working vars from chaining hash
    logic               round_en;    // run one compression round
    logic [ROUND_W-1:0] round_idx;   // current round number
    logic               update;      // add working vars into chaining hash
    logic               finish;      // capture digest, restart chaining hash
    logic               emit_shift;  // digest word taken, advance buffer
  } cmd_t;

endpackage

// ===== hdl/sha256_if.sv =====
// ----------------------------------------------------------------------------
// sha256_if
// Valid/ready channels of the SHA-256 block hasher: message words in,
// digest words out.
// ----------------------------------------------------------------------------
interface sha256_in_if import sha256_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] message_word;
  logic              message_end;

  modport source (output valid, output message_word, output message_end, input ready);
  modport sink   (input valid, input message_word, input message_end, output ready);
endinterface

interface sha256_out_if import sha256_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  digest_index;
  logic              digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_index,
                  input digest_last, output ready);
endinterface

// ===== hdl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer of the hasher: counts words into a block, steps the 64 rounds,
// triggers the hash update and walks the digest out word by word.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             message_end_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IDX_W-1:0] digest_index_o,
  output logic             digest_last_o,
  output cmd_t             cmd_o
);

  state_e             state_q, state_d;
  logic [POS_W-1:0]   word_pos_q;
  logic [ROUND_W-1:0] round_q;
  logic               end_q;
  logic               emit_busy_q;
  logic [IDX_W-1:0]   emit_idx_q;

  logic in_fire, out_fire, last_word;

  assign last_word = (word_pos_q == LAST_POS);
  // the closing word of a block waits until the digest buffer is free
  assign in_ready_o = (state_q == ST_LOAD) && !(last_word && emit_busy_q);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = emit_busy_q && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && last_word) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_q == LAST_ROUND) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Outputs and commands
  always_comb begin
    out_valid_o        = emit_busy_q;
    digest_index_o     = emit_idx_q;
    digest_last_o      = (emit_idx_q == LAST_IDX);
    cmd_o              = '0;
    cmd_o.load_word    = in_fire;
    cmd_o.start        = in_fire && last_word;
    cmd_o.round_en     = (state_q == ST_ROUND);
    cmd_o.round_idx    = round_q;
    cmd_o.update       = (state_q == ST_UPDATE);
    cmd_o.finish       = (state_q == ST_UPDATE) && end_q;
    cmd_o.emit_shift   = out_fire;
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      word_pos_q  <= '0;
      round_q     <= '0;
      end_q       <= 1'b0;
      emit_busy_q <= 1'b0;
      emit_idx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) word_pos_q <= word_pos_q + POS_W'(1);
      if (in_fire && last_word) begin
        round_q <= '0;
        end_q   <= message_end_i;
      end else if (state_q == ST_ROUND) begin
        round_q <= round_q + ROUND_W'(1);
      end
      // digest walk
      if (cmd_o.finish) begin
        emit_busy_q <= 1'b1;
        emit_idx_q  <= '0;
      end else if (out_fire) begin
        emit_idx_q <= emit_idx_q + IDX_W'(1);
        if (emit_idx_q == LAST_IDX) emit_busy_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath of the hasher: schedule window shift register, round unit over
// the a..h working registers, chaining hash and digest output buffer.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [WORD_W-1:0] message_word_i,
  output logic [WORD_W-1:0] digest_word_o
);

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  logic [WORD_W-1:0] win_q   [BLOCK_WORDS];
  logic [WORD_W-1:0] var_q   [HASH_WORDS];
  logic [WORD_W-1:0] chain_q [HASH_WORDS];
  logic [WORD_W-1:0] dig_q   [HASH_WORDS];

  logic [WORD_W-1:0] sched_w, shift_in, mix0_w, mix1_w;
  logic [WORD_W-1:0] sum0_w, sum1_w, ch_w, maj_w, t1_w, t2_w;
  logic [WORD_W-1:0] new_chain [HASH_WORDS];

  // Message schedule: next word from the sliding window
  assign mix0_w   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
  assign mix1_w   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
  assign sched_w  = mix1_w + win_q[9] + mix0_w + win_q[0];
  assign shift_in = cmd_i.load_word ? message_word_i : sched_w;

  // Round function; win_q[0] is the round's schedule word
  assign sum1_w = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
  assign sum0_w = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
  assign ch_w   = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
  assign maj_w  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
  assign t1_w   = var_q[7] + sum1_w + ch_w + ROUND_K[cmd_i.round_idx] + win_q[0];
  assign t2_w   = sum0_w + maj_w;

  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      new_chain[i] = chain_q[i] + var_q[i];
    end
  end

  // Window, working registers and digest buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word || cmd_i.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BLOCK_WORDS-1] <= shift_in;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        var_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round_en) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1_w;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1_w + t2_w;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        dig_q[i] <= new_chain[i];
      end
    end else if (cmd_i.emit_shift) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
      dig_q[HASH_WORDS-1] <= dig_q[HASH_WORDS-1];
    end
  end

  // Chaining hash: accumulate, or restart after the final block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_q[i] <= INIT_HASH[i];
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_q[i] <= cmd_i.finish ? INIT_HASH[i] : new_chain[i];
      end
    end
  end

  assign digest_word_o = dig_q[0];

endmodule

// ===== hdl/sha256_block_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_block_hash
// SHA-256 over a padded message, one 32-bit word per request.
// ----------------------------------------------------------------------------
// Usage:
//   msg_i  : message words, most significant byte first; message_end is
//            honored only on the sixteenth word of a block.
//   dig_o  : eight digest words H0..H7 with digest_index 0..7 and
//            digest_last on the eighth.
// Timing: one round per cycle in a single round unit, so a block costs
//   16 word requests, 64 rounds and one update step. The first digest
//   word is valid the cycle after the update; one word leaves per cycle
//   when dig_o is ready.
// Reset: chaining hash returns to the standard initial values, the word
//   count clears and no digest is pending.
// Stall: a digest waits in its own buffer, and the next message keeps
//   loading meanwhile; only the sixteenth word of the next block waits
//   until the whole digest has been taken.
// ----------------------------------------------------------------------------
module sha256_block_hash import sha256_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    msg_i,
  sha256_out_if.source dig_o
);

  cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (msg_i.valid),
    .message_end_i  (msg_i.message_end),
    .in_ready_o     (msg_i.ready),
    .out_ready_i    (dig_o.ready),
    .out_valid_o    (dig_o.valid),
    .digest_index_o (dig_o.digest_index),
    .digest_last_o  (dig_o.digest_last),
    .cmd_o          (cmd)
  );

  sha256_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_word_i (msg_i.message_word),
    .digest_word_o  (dig_o.digest_word)
  );

endmodule

// ===== hdl/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks of the digest stream of the hasher, bound to the top.
// ----------------------------------------------------------------------------
module sha256_checker import sha256_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [WORD_W-1:0] digest_word_i,
  input logic [IDX_W-1:0]  digest_index_i,
  input logic              digest_last_i
);

  // last marker sits on the final index only
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (digest_last_i == (digest_index_i == LAST_IDX)))
    else $error("digest_last does not match digest_index");

  // a digest starts at index zero
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> (digest_index_i == '0))
    else $error("digest does not start at index 0");

  // words of one digest follow without a gap, index counting up
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !digest_last_i) |=>
      (out_valid_i && (digest_index_i == $past(digest_index_i) + IDX_W'(1))))
    else $error("digest word missing or out of order");

  // stalled digest word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(digest_word_i)))
    else $error("digest word changed while stalled");

endmodule

bind sha256_block_hash sha256_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (dig_o.valid),
  .out_ready_i    (dig_o.ready),
  .digest_word_i  (dig_o.digest_word),
  .digest_index_i (dig_o.digest_index),
  .digest_last_i  (dig_o.digest_last)
);
